/* design/contiguous_unit_allocator_unit_assert.svh */
// assertion macros for the contiguous unit allocator
// used by contiguous_unit_allocator_unit.sv; expects a clock named clk and reset rst
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CUA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cua assertion failed");

// next-cycle implication
`define CUA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cua assertion failed");

`endif

/* design/cua_pkg.sv */
// shared types and codes for the contiguous unit allocator
// no dependencies
`default_nettype none
package cua_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_TICK  = 2'd1,
    OP_FRAG  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] STRAT_BEST  = 2'd0;
  localparam logic [1:0] STRAT_FIRST = 2'd1;
  localparam logic [1:0] STRAT_NEXT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN0,
    ST_SCAN1,
    ST_WRITE,
    ST_TICK,
    ST_FRAG,
    ST_FINISH
  } state_t;

  localparam logic [1:0] REG_UNITS_IN_USE = 2'd0;

endpackage
`default_nettype wire

/* design/contiguous_unit_allocator_unit.sv */
// Contiguous unit allocator. Units live in a ring of cells that rotates one
// place a cycle; the unit at the head cell is examined and rewritten as it
// passes, then sent to the tail. A full rotation returns every unit home.
// Input channel (in_valid/in_ready) takes one operation; output channel
// (out_valid/out_ready) returns one result per operation.
// An allocate searches the ring in ST_SCAN0 and ST_SCAN1 and, on success,
// writes the run in ST_WRITE; tick and fragment count pass the ring in
// ST_TICK or ST_FRAG; clear goes straight to ST_FINISH.
// One operation is in flight at a time; in_ready is high only when idle.
// A result waits in the output register while the receiver stalls; the
// block finishes the next operation's work and then holds it until the
// output register is taken.
// Reset clears every unit, the next-fit position and sets units_in_use to
// 256. units_in_use is written over the APB port at address 0 and should
// only change while the block is idle.
`default_nettype none
module contiguous_unit_allocator_unit
  import cua_pkg::*;
#(
  parameter int UNITS         = 256,
  parameter int LIFETIME_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [1:0]  strategy,
  input  wire logic [8:0]  request_size,
  input  wire logic [7:0]  duration,
  input  wire logic [8:0]  frag_limit,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic [7:0]       probes,
  output logic [7:0]       fragments,
  output logic [7:0]       placed_at
);

  localparam int NB = $clog2(UNITS + 1);
  localparam int W  = (NB > 9) ? NB : 9;
  localparam int PW = $clog2(UNITS);
  localparam int L  = LIFETIME_BITS;

  // configuration register
  logic [8:0] units_in_use;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      units_in_use <= 9'd256;
    end else if (psel && penable && pwrite && (paddr[2] == REG_UNITS_IN_USE[0])) begin
      units_in_use <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_UNITS_IN_USE[0]) begin
      prdata[8:0] = units_in_use;
    end
  end

  // managed unit count
  logic [W-1:0] n;
  always_comb begin
    if (W'(units_in_use) > W'(UNITS)) begin
      n = W'(UNITS);
    end else begin
      n = W'(units_in_use);
    end
  end

  // latched operation
  op_t        op;
  logic [1:0] strat;
  logic [W-1:0] size;
  logic [L-1:0] dur;
  logic [W-1:0] limit;
  logic [W-1:0] origin;
  logic [PW-1:0] nf_pos;

  // control state
  state_t state, state_next;
  logic [PW-1:0] pos;
  logic pos_last;
  logic rotating;
  logic in_xfer, out_free;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pos_last = (pos == PW'(UNITS - 1));
  assign rotating = (state == ST_SCAN0) || (state == ST_SCAN1) || (state == ST_WRITE) ||
                    (state == ST_TICK) || (state == ST_FRAG);

  // search state
  logic [W-1:0]   run_len, run_start;
  logic [W:0]     best_len;
  logic [W-1:0]   best_at, found_at;
  logic           found, have_best;
  logic [7:0]     probe_cnt, frag_cnt;
  logic           success;
  logic [W-1:0]   at;

  assign success = found || have_best;
  assign at      = found ? found_at : best_at;

  // ring of cells
  logic [L-1:0] q   [UNITS];
  logic [L-1:0] head_new;
  logic         clr_all;

  assign clr_all = (state == ST_FINISH) && (op == OP_CLEAR) && out_free;

  for (genvar i = 0; i < UNITS; i++) begin : g_ring
    logic [L-1:0] d;
    if (i == UNITS - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = q[i+1];
    end
    cua_cell #(.LIFETIME_BITS(L)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(rotating),
      .clr  (clr_all),
      .d    (d),
      .q    (q[i])
    );
  end

  // head examination
  logic [L-1:0] v;
  logic [W-1:0] idx, last_idx, rl_new, rs_new, offs;
  logic busy, in_range, scan_act, last, endrun, req_ok;
  logic frag_hit;
  logic [W-1:0] frun_new;

  assign v        = q[0];
  assign idx      = W'(pos);
  assign busy     = (v != '0);
  assign in_range = (idx < n);
  assign req_ok   = (n != '0) && (size != '0) && (strat != 2'd3);
  assign last_idx = (origin == '0) ? (n - W'(1)) : (origin - W'(1));
  assign last     = (idx == n - W'(1)) || (idx == last_idx);
  assign scan_act = req_ok && !found && in_range &&
                    (((state == ST_SCAN0) && (idx >= origin)) ||
                     ((state == ST_SCAN1) && (idx < origin)));
  assign rl_new   = busy ? run_len : (run_len + W'(1));
  assign rs_new   = (!busy && (run_len == '0)) ? idx : run_start;
  assign endrun   = (busy || last) && (rl_new != '0);
  assign offs     = idx - at;
  assign frun_new = busy ? '0 : (run_len + W'(1));
  assign frag_hit = (busy && (run_len != '0) && (run_len <= limit)) ||
                    ((idx == n - W'(1)) && !busy && (frun_new <= limit));

  // new head value sent to the tail
  always_comb begin
    head_new = v;
    case (state)
      ST_WRITE: begin
        if (in_range && (idx >= at) && (offs < size)) begin
          head_new = dur;
        end
      end
      ST_TICK: begin
        if (in_range && busy) begin
          head_new = v - L'(1);
        end
      end
      default: begin
        head_new = v;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (op_t'(operation))
            OP_ALLOC: state_next = ST_SCAN0;
            OP_TICK:  state_next = ST_TICK;
            OP_FRAG:  state_next = ST_FRAG;
            default:  state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN0: if (pos_last) state_next = ST_SCAN1;
      ST_SCAN1: if (pos_last) state_next = success ? ST_WRITE : ST_FINISH;
      ST_WRITE: if (pos_last) state_next = ST_FINISH;
      ST_TICK:  if (pos_last) state_next = ST_FINISH;
      ST_FRAG:  if (pos_last) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // rotation position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (rotating) begin
      pos <= pos_last ? '0 : (pos + PW'(1));
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op    <= op_t'(operation);
      strat <= strategy;
      size  <= W'(request_size);
      dur   <= L'(duration);
      limit <= W'(frag_limit);
      if ((strategy == STRAT_NEXT) && (W'(nf_pos) < n)) begin
        origin <= W'(nf_pos);
      end else begin
        origin <= '0;
      end
    end
  end

  // search and fragment scan
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      run_len   <= '0;
      run_start <= '0;
      best_len  <= {1'b0, n} + (W+1)'(1);
      best_at   <= '0;
      found_at  <= '0;
      found     <= 1'b0;
      have_best <= 1'b0;
      probe_cnt <= '0;
      frag_cnt  <= '0;
    end else if (scan_act) begin
      run_start <= rs_new;
      run_len   <= endrun ? '0 : rl_new;
      if (endrun) begin
        if (strat == STRAT_BEST) begin
          if (rl_new == size) begin
            found    <= 1'b1;
            found_at <= rs_new;
          end else if ((rl_new > size) && ({1'b0, rl_new} < best_len)) begin
            best_len  <= {1'b0, rl_new};
            best_at   <= rs_new;
            have_best <= 1'b1;
          end else if (probe_cnt != 8'hFF) begin
            probe_cnt <= probe_cnt + 8'd1;
          end
        end else begin
          if (rl_new >= size) begin
            found    <= 1'b1;
            found_at <= rs_new;
          end else if (probe_cnt != 8'hFF) begin
            probe_cnt <= probe_cnt + 8'd1;
          end
        end
      end
    end else if ((state == ST_FRAG) && in_range) begin
      run_len <= frun_new;
      if (frag_hit && (frag_cnt != 8'hFF)) begin
        frag_cnt <= frag_cnt + 8'd1;
      end
    end
  end

  // next-fit position
  always_ff @(posedge clk) begin
    if (rst) begin
      nf_pos <= '0;
    end else if ((state == ST_WRITE) && pos_last && (strat == STRAT_NEXT)) begin
      nf_pos <= PW'(at);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      case (op)
        OP_ALLOC: begin
          status    <= !success;
          probes    <= success ? probe_cnt : 8'd0;
          fragments <= '0;
          placed_at <= success ? at[7:0] : 8'd0;
        end
        OP_FRAG: begin
          status    <= 1'b0;
          probes    <= '0;
          fragments <= frag_cnt;
          placed_at <= '0;
        end
        default: begin
          status    <= 1'b0;
          probes    <= '0;
          fragments <= '0;
          placed_at <= '0;
        end
      endcase
    end
  end

  `include "contiguous_unit_allocator_unit_assert.svh"

  `CUA_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state != ST_IDLE)
  `CUA_ASSERT_IMPL(a_ring_aligned, state == ST_IDLE, pos == '0)
  `CUA_ASSERT_IMPL(a_write_has_fit, state == ST_WRITE, success)
  `CUA_ASSERT_IMPL(a_fail_clean, out_valid && status, (probes == '0) && (placed_at == '0))

endmodule
`default_nettype wire

/* design/cua_cell.sv */
// one unit of the lifetime ring: holds a lifetime, shifts toward the head
// depends on nothing
`default_nettype none
module cua_cell #(
  parameter int LIFETIME_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire logic                     clr,
  input  wire logic [LIFETIME_BITS-1:0] d,
  output logic      [LIFETIME_BITS-1:0] q
);

  logic [LIFETIME_BITS-1:0] lifetime;

  // clear wins over shift
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      lifetime <= '0;
    end else if (shift) begin
      lifetime <= d;
    end
  end

  assign q = lifetime;

endmodule
`default_nettype wire

/* sim/contiguous_unit_allocator_unit_tb.sv */
// self-checking testbench for the contiguous unit allocator
// depends on cua_pkg and contiguous_unit_allocator_unit from the design folder
// directed table first, then random traffic checked by a behavioral predictor
`default_nettype none
module contiguous_unit_allocator_unit_tb;
  import cua_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] strat;
    logic [8:0] size;
    logic [7:0] dur;
    logic [8:0] limit;
  } request_t;

  typedef struct packed {
    logic       status;
    logic [7:0] probes;
    logic [7:0] fragments;
    logic [7:0] placed_at;
  } reply_t;

  // directed row: request, optional typed-in answer
  typedef struct packed {
    request_t   req;
    logic       known;
    reply_t     rep;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0, strategy = '0;
  logic [8:0]  request_size = '0, frag_limit = '0;
  logic [7:0]  duration = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [7:0]  probes, fragments, placed_at;

  contiguous_unit_allocator_unit uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] life_mirror [DEPTH];
  int unsigned next_fit_start;
  int unsigned units_cfg;

  // register settings swept by the random part
  int unsigned unit_settings [7] = '{1, 2, 0, 257, 511, 37, 256};

  reply_t pending_replies[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit finished = 1'b0;
  int allocs = 0, allocs_ok = 0, ticks = 0, frag_ops = 0, clears = 0;

  function automatic int unsigned managed_units();
    return (units_cfg > DEPTH) ? DEPTH : units_cfg;
  endfunction

  // placement search, returns 1 on success
  function automatic bit find_run(input int unsigned strat, input int unsigned size,
                                  output int unsigned at, output int unsigned probed);
    int unsigned n, origin, idx, run_start, run_len, best_len, best_at, cnt;
    bit busy, have_best;
    n = managed_units();
    origin = 0; run_start = 0; run_len = 0; best_len = n + 1; best_at = 0;
    cnt = 0; have_best = 0; at = 0; probed = 0;
    if (n == 0 || size == 0 || strat > 2) return 0;
    if (strat == STRAT_NEXT && next_fit_start < n) origin = next_fit_start;
    for (int unsigned k = 0; k < n; k++) begin
      idx = origin + k;
      if (idx >= n) idx -= n;
      busy = life_mirror[idx] != 0;
      if (!busy) begin
        if (run_len == 0) run_start = idx;
        run_len++;
      end
      if ((busy || idx == n - 1 || k == n - 1) && run_len > 0) begin
        if (strat == STRAT_BEST) begin
          if (run_len == size) begin
            at = run_start; probed = cnt; return 1;
          end else if (run_len > size && run_len < best_len) begin
            best_len = run_len; best_at = run_start; have_best = 1;
          end else cnt++;
        end else begin
          if (run_len >= size) begin
            at = run_start; probed = cnt; return 1;
          end
          cnt++;
        end
        run_len = 0;
      end
    end
    if (have_best) begin
      at = best_at; probed = cnt; return 1;
    end
    return 0;
  endfunction

  function automatic reply_t predict_reply(input request_t r);
    reply_t o;
    int unsigned n, at, probed, frags, run;
    o = '0;
    n = managed_units();
    case (op_t'(r.op))
      OP_ALLOC: begin
        allocs++;
        if (find_run(r.strat, r.size, at, probed)) begin
          allocs_ok++;
          for (int unsigned i = 0; i < r.size && at + i < n; i++) life_mirror[at + i] = r.dur;
          if (r.strat == STRAT_NEXT) next_fit_start = at;
          o.probes = (probed > 255) ? 8'd255 : probed[7:0];
          o.placed_at = at[7:0];
        end else o.status = 1'b1;
      end
      OP_TICK: begin
        ticks++;
        for (int unsigned i = 0; i < n; i++)
          if (life_mirror[i] != 0) life_mirror[i] = life_mirror[i] - 8'd1;
      end
      OP_FRAG: begin
        frag_ops++;
        frags = 0; run = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (life_mirror[i] == 0) run++;
          else begin
            if (run > 0 && run <= r.limit) frags++;
            run = 0;
          end
        end
        if (run > 0 && run <= r.limit) frags++;
        o.fragments = (frags > 255) ? 8'd255 : frags[7:0];
      end
      default: begin
        clears++;
        for (int i = 0; i < DEPTH; i++) life_mirror[i] = '0;
      end
    endcase
    return o;
  endfunction

  // output side: compare each transfer with the next predicted reply
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status); errors++;
          end
          if (probes !== want.probes) begin
            $error("probes expected %0d actual %0d", want.probes, probes); errors++;
          end
          if (fragments !== want.fragments) begin
            $error("fragments expected %0d actual %0d", want.fragments, fragments); errors++;
          end
          if (placed_at !== want.placed_at) begin
            $error("placed_at expected %0d actual %0d", want.placed_at, placed_at); errors++;
          end
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    int burst;
    @(posedge clk);
    while (1) begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!finished && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up into the next transfer unless an idle gap is taken
  task automatic send_request(input request_t r, input bit known, input reply_t rep);
    reply_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.op; strategy <= r.strat; request_size <= r.size;
    duration <= r.dur; frag_limit <= r.limit;
    do @(posedge clk); while (!in_ready);
    p = predict_reply(r);
    if (known && p !== rep) begin
      $error("typed-in answer disagrees: expected %h, predictor %h", rep, p);
      errors++;
    end
    pending_replies.push_back(p);
  endtask

  // wait for idle, then apb write of units_in_use
  task automatic write_units(input int unsigned value);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_UNITS_IN_USE[0], 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    units_cfg = value & 32'h1FF;
  endtask

  function automatic request_t mk(input logic [1:0] op, input logic [1:0] st,
                                  input int unsigned sz, input int unsigned d,
                                  input int unsigned lim);
    mk = '{op: op, strat: st, size: sz[8:0], dur: d[7:0], limit: lim[8:0]};
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    int unsigned n;
    n = managed_units();
    pick = $urandom_range(0, 99);
    r = mk(OP_ALLOC, 2'($urandom_range(0, 2)), 1, $urandom_range(1, 255),
           $urandom_range(0, 511));
    if (pick < 60) begin
      // mostly small requests so the store fragments
      if ($urandom_range(0, 9) == 0) r.size = 9'($urandom_range(0, 511));
      else r.size = 9'($urandom_range(1, (n < 24) ? ((n == 0) ? 1 : n) : 24));
      if ($urandom_range(0, 19) == 0) r.strat = 2'd3;
      if ($urandom_range(0, 19) == 0) r.dur = 8'd0;
      if ($urandom_range(0, 3) == 0) r.dur = 8'($urandom_range(1, 8));
    end else if (pick < 82) r.op = OP_TICK;
    else if (pick < 96) begin
      r.op = OP_FRAG;
      r.limit = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) :
                                               9'($urandom_range(0, 16));
    end else r.op = OP_CLEAR;
    return r;
  endfunction

  row_t directed [$];

  initial begin
    reply_t none;
    none = '0;
    for (int i = 0; i < DEPTH; i++) life_mirror[i] = '0;
    next_fit_start = 0;
    units_cfg = 256;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: extremes, every op, failures, zero duration
    directed.push_back('{mk(OP_FRAG, STRAT_BEST, 1, 1, 256), 1, '{0, 0, 1, 0}});
    directed.push_back('{mk(OP_FRAG, STRAT_BEST, 1, 1, 255), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 0, 5, 0), 1, '{1, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, 2'd3, 4, 5, 0), 1, '{1, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 257, 5, 0), 1, '{1, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 511, 255, 0), 1, '{1, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_BEST, 256, 255, 0), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 1, 1, 0), 1, '{1, 0, 0, 0}});
    directed.push_back('{mk(OP_CLEAR, STRAT_BEST, 0, 0, 0), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 3, 2, 0), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_ALLOC, STRAT_NEXT, 4, 1, 0), 1, '{0, 0, 0, 3}});
    directed.push_back('{mk(OP_ALLOC, STRAT_NEXT, 2, 9, 0), 0, none});
    directed.push_back('{mk(OP_ALLOC, STRAT_BEST, 5, 0, 0), 0, none});
    directed.push_back('{mk(OP_TICK, 2'd3, 511, 255, 511), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_FRAG, STRAT_BEST, 0, 0, 4), 0, none});
    directed.push_back('{mk(OP_ALLOC, STRAT_BEST, 4, 128, 0), 0, none});
    directed.push_back('{mk(OP_ALLOC, STRAT_FIRST, 200, 7, 0), 0, none});
    directed.push_back('{mk(OP_TICK, STRAT_BEST, 0, 0, 0), 0, none});
    directed.push_back('{mk(OP_FRAG, STRAT_BEST, 0, 0, 0), 1, '{0, 0, 0, 0}});
    directed.push_back('{mk(OP_FRAG, STRAT_BEST, 0, 0, 511), 0, none});
    foreach (directed[i]) send_request(directed[i].req, directed[i].known, directed[i].rep);

    // several register settings, extremes included
    foreach (unit_settings[j]) begin
      write_units(unit_settings[j]);
      for (int k = 0; k < RANDOM_ITEMS / 8; k++)
        send_request(random_request(), 1'b0, none);
    end

    // tail with no idling on either side
    quiet = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS / 8; k++) send_request(random_request(), 1'b0, none);
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    finished = 1'b1;
    $display("covered %0d allocates (%0d placed), %0d ticks, %0d fragment counts, %0d clears",
             allocs, allocs_ok, ticks, frag_ops, clears);
    $display("units_in_use swept through 1, 2, 0, 257, 511, 37 and 256");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
